FILE: hdl/adjacency_matrix_graph_store_core_assert.svh
// Assertion macros for the graph store core.
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_CORE_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AMGS_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AMGS_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/amgs_pkg.sv
// Shared types and codes of the graph store core.
package amgs_pkg;

	localparam int ID_PORT_W  = 16;
	localparam int DEG_W      = 7;
	localparam int NODE_TOT_W = 7;
	localparam int EDGE_TOT_W = 13;

	typedef logic [1:0] opcode_t;
	typedef logic [2:0] status_t;

	localparam opcode_t OP_INS_NODE = 2'd0;
	localparam opcode_t OP_INS_EDGE = 2'd1;
	localparam opcode_t OP_QUERY    = 2'd2;
	localparam opcode_t OP_LIST     = 2'd3;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_DUP       = 3'd1;
	localparam status_t ST_FULL      = 3'd2;
	localparam status_t ST_NOT_FOUND = 3'd3;
	localparam status_t ST_CONNECTED = 3'd4;

	typedef struct packed {
		status_t                status;
		logic                   connected;
		logic                   nvalid;
		logic [ID_PORT_W-1:0]   nid;
		logic [DEG_W-1:0]       deg;
		logic                   last;
	} res_t;

endpackage

FILE: hdl/adjacency_matrix_graph_store_core.sv
// Directed graph store: id table, adjacency bit matrix and out-degrees in RAM.
//
// Command channel: an operation (opcode, src_id, dst_id) is taken at a rising
// edge with start high and busy low. Results appear on the result ports for
// exactly one cycle each, marked by done; the receiver takes every result and
// cannot hold them off. last marks the final result of an operation.
// The ids are looked up by a scan of the id RAM, one entry a cycle, and every
// operation but a neighbour listing ends in a single result. Insert edge
// reads, modifies and writes back one matrix row and one degree entry after
// the scan. A neighbour listing scans the row held in the matrix RAM read
// port, one slot a cycle, and neighbours stream out at up to one a cycle.
// busy stays high until the final result is shown; a new operation can be
// taken in the cycle that shows it. One operation is in flight at a time, so
// accesses to one RAM entry never overlap.
// Reset clears the state, the control flags and the node and edge counts,
// not the RAMs. Insert node zeroes the row and degree of its new slot, so no
// clearing pass runs and the block is ready in the first cycle after reset.
`include "adjacency_matrix_graph_store_core_assert.svh"

module adjacency_matrix_graph_store_core #(
	parameter int MAX_NODE_SLOTS = 64,
	parameter int ID_BITS        = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  amgs_pkg::opcode_t                       opcode,
	input  logic [amgs_pkg::ID_PORT_W-1:0]          src_id,
	input  logic [amgs_pkg::ID_PORT_W-1:0]          dst_id,
	output logic                                    busy,
	output logic                                    done,
	output amgs_pkg::status_t                       status,
	output logic                                    connected,
	output logic                                    neighbour_valid,
	output logic [amgs_pkg::ID_PORT_W-1:0]          neighbour_id,
	output logic [amgs_pkg::DEG_W-1:0]              out_degree,
	output logic [amgs_pkg::NODE_TOT_W-1:0]         node_total,
	output logic [amgs_pkg::EDGE_TOT_W-1:0]         edge_total,
	output logic                                    last
);

	import amgs_pkg::*;

	localparam int SLOT_W = (MAX_NODE_SLOTS > 1) ? $clog2(MAX_NODE_SLOTS) : 1;
	localparam int CNT_W  = $clog2(MAX_NODE_SLOTS + 1);
	localparam int ID_W   = (ID_BITS < ID_PORT_W) ? ID_BITS : ID_PORT_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_LOOK   = 3'd1;
	localparam logic [2:0] S_ROW    = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_LIST   = 3'd4;

	logic [2:0]                state_q;
	opcode_t                   op_q;
	logic [ID_W-1:0]           src_q;
	logic [ID_W-1:0]           dst_q;
	logic [CNT_W-1:0]          scan_q;
	logic [CNT_W-1:0]          node_cnt_q;
	logic [EDGE_TOT_W-1:0]     edge_cnt_q;
	logic                      a_found_q;
	logic                      b_found_q;
	logic [SLOT_W-1:0]         a_slot_q;
	logic [SLOT_W-1:0]         b_slot_q;
	logic                      pend_q;
	logic [ID_W-1:0]           pend_id_q;
	logic                      done_q;
	res_t                      res_q;

	logic                      look_s1;
	logic                      list_s1;
	logic                      hit_s1;
	logic [SLOT_W-1:0]         idx_s1;

	logic                      scan_lt;
	logic [SLOT_W-1:0]         scan_slot;
	logic [SLOT_W-1:0]         new_slot;

	logic                      id_we;
	logic                      id_re;
	logic [ID_W-1:0]           id_rd;
	logic                      mat_we;
	logic                      mat_re;
	logic [SLOT_W-1:0]         mat_waddr;
	logic [MAX_NODE_SLOTS-1:0] mat_wdata;
	logic [MAX_NODE_SLOTS-1:0] mat_rd;
	logic                      deg_we;
	logic [DEG_W-1:0]          deg_wdata;
	logic [DEG_W-1:0]          deg_rd;
	logic [DEG_W-1:0]          deg_inc;
	logic [DEG_W-1:0]          a_deg;

	logic                      res_valid;
	res_t                      res;
	logic                      node_inc;
	logic                      edge_inc;

	assign scan_lt   = scan_q < node_cnt_q;
	assign scan_slot = scan_q[SLOT_W-1:0];
	assign new_slot  = node_cnt_q[SLOT_W-1:0];
	assign deg_inc   = deg_rd + DEG_W'(1);
	assign a_deg     = a_found_q ? deg_rd : '0;

	assign id_re  = ((state_q == S_LOOK) || (state_q == S_LIST)) && scan_lt;
	assign mat_re = (state_q == S_ROW);

	amgs_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODE_SLOTS)) u_id_ram (
		.clk   (clk),
		.we    (id_we),
		.waddr (new_slot),
		.wdata (src_q),
		.re    (id_re),
		.raddr (scan_slot),
		.rdata (id_rd)
	);

	amgs_ram #(.WIDTH(MAX_NODE_SLOTS), .DEPTH(MAX_NODE_SLOTS)) u_mat_ram (
		.clk   (clk),
		.we    (mat_we),
		.waddr (mat_waddr),
		.wdata (mat_wdata),
		.re    (mat_re),
		.raddr (a_slot_q),
		.rdata (mat_rd)
	);

	amgs_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODE_SLOTS)) u_deg_ram (
		.clk   (clk),
		.we    (deg_we),
		.waddr (mat_waddr),
		.wdata (deg_wdata),
		.re    (mat_re),
		.raddr (a_slot_q),
		.rdata (deg_rd)
	);

	// Decide the operation once the row and degree of the source are read.
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		id_we     = 1'b0;
		mat_we    = 1'b0;
		mat_waddr = new_slot;
		mat_wdata = '0;
		deg_we    = 1'b0;
		deg_wdata = '0;
		node_inc  = 1'b0;
		edge_inc  = 1'b0;
		res.last  = 1'b1;
		if (state_q == S_DECIDE) begin
			unique case (op_q)
				OP_INS_NODE: begin
					res_valid = 1'b1;
					if (a_found_q) begin
						res.status = ST_DUP;
						res.deg    = deg_rd;
					end else if (node_cnt_q == CNT_W'(MAX_NODE_SLOTS)) begin
						res.status = ST_FULL;
					end else begin
						res.status = ST_OK;
						id_we      = 1'b1;
						mat_we     = 1'b1;
						deg_we     = 1'b1;
						node_inc   = 1'b1;
					end
				end
				OP_INS_EDGE: begin
					res_valid = 1'b1;
					res.deg   = a_deg;
					if (!(a_found_q && b_found_q)) begin
						res.status = ST_NOT_FOUND;
					end else if (mat_rd[b_slot_q]) begin
						res.status = ST_CONNECTED;
					end else begin
						res.status          = ST_OK;
						res.deg             = deg_inc;
						mat_we              = 1'b1;
						mat_waddr           = a_slot_q;
						mat_wdata           = mat_rd;
						mat_wdata[b_slot_q] = 1'b1;
						deg_we              = 1'b1;
						deg_wdata           = deg_inc;
						edge_inc            = 1'b1;
					end
				end
				OP_QUERY: begin
					res_valid = 1'b1;
					res.deg   = a_deg;
					if (!(a_found_q && b_found_q)) begin
						res.status = ST_NOT_FOUND;
					end else begin
						res.status    = ST_OK;
						res.connected = mat_rd[b_slot_q];
					end
				end
				OP_LIST: begin
					if (!a_found_q) begin
						res_valid  = 1'b1;
						res.status = ST_NOT_FOUND;
					end
				end
				default: ;
			endcase
		end else if (state_q == S_LIST) begin
			res.status = ST_OK;
			res.deg    = deg_rd;
			res.nvalid = 1'b1;
			res.nid    = ID_PORT_W'(pend_id_q);
			// Hold one neighbour back so the final one can carry last.
			if (list_s1 && hit_s1 && pend_q) begin
				res_valid = 1'b1;
				res.last  = 1'b0;
			end else if (!scan_lt && !list_s1) begin
				res_valid  = 1'b1;
				res.nvalid = pend_q;
				if (!pend_q)
					res.nid = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			node_cnt_q <= '0;
			edge_cnt_q <= '0;
			done_q     <= 1'b0;
			look_s1    <= 1'b0;
			list_s1    <= 1'b0;
			a_found_q  <= 1'b0;
			b_found_q  <= 1'b0;
			pend_q     <= 1'b0;
			scan_q     <= '0;
		end else begin
			done_q  <= res_valid;
			look_s1 <= (state_q == S_LOOK) && scan_lt;
			list_s1 <= (state_q == S_LIST) && scan_lt;
			if (node_inc)
				node_cnt_q <= node_cnt_q + CNT_W'(1);
			if (edge_inc)
				edge_cnt_q <= edge_cnt_q + EDGE_TOT_W'(1);
			if (id_re)
				scan_q <= scan_q + CNT_W'(1);

			// Keep the first matching slot of each id.
			if (look_s1) begin
				if (!a_found_q && (id_rd == src_q)) begin
					a_found_q <= 1'b1;
					a_slot_q  <= idx_s1;
				end
				if (!b_found_q && (id_rd == dst_q)) begin
					b_found_q <= 1'b1;
					b_slot_q  <= idx_s1;
				end
			end
			if (list_s1 && hit_s1) begin
				pend_q    <= 1'b1;
				pend_id_q <= id_rd;
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q      <= opcode;
						src_q     <= src_id[ID_W-1:0];
						dst_q     <= dst_id[ID_W-1:0];
						scan_q    <= '0;
						a_found_q <= 1'b0;
						b_found_q <= 1'b0;
						a_slot_q  <= '0;
						b_slot_q  <= '0;
						state_q   <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (!scan_lt && !look_s1)
						state_q <= S_ROW;
				end
				S_ROW: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					scan_q <= '0;
					pend_q <= 1'b0;
					if ((op_q == OP_LIST) && a_found_q)
						state_q <= S_LIST;
					else
						state_q <= S_IDLE;
				end
				S_LIST: begin
					if (!scan_lt && !list_s1)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_slot;
		hit_s1 <= mat_rd[scan_slot];
		if (res_valid)
			res_q <= res;
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign status          = res_q.status;
	assign connected       = res_q.connected;
	assign neighbour_valid = res_q.nvalid;
	assign neighbour_id    = res_q.nid;
	assign out_degree      = res_q.deg;
	assign node_total      = NODE_TOT_W'(node_cnt_q);
	assign edge_total      = edge_cnt_q;
	assign last            = res_q.last;

	`AMGS_CHECK_NEXT(a_final_then_quiet, done && last, !done, "result after final result")
	`AMGS_CHECK_NEXT(a_take_then_busy, start && !busy, busy && !done, "transfer left block idle")
	`AMGS_CHECK(a_neighbour_ok, done && neighbour_valid, (status == ST_OK) && !connected,
		"neighbour result with bad status")
	`AMGS_CHECK(a_count_bound, 1'b1, node_cnt_q <= CNT_W'(MAX_NODE_SLOTS), "node count overrun")

endmodule

FILE: hdl/amgs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module amgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule
